@@ src/lsgc_pkg.sv @@
// shared types and constants for the laser scan to grid cell block
`timescale 1ns / 1ps

package lsgc_pkg;

    // apb register map, one 32-bit word per register
    localparam int unsigned CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_START_ANGLE   = 3'd0,
        REG_ANGLE_STEP    = 3'd1,
        REG_RANGE_MIN_MM  = 3'd2,
        REG_RANGE_MAX_MM  = 3'd3,
        REG_ROBOT_X_CELLS = 3'd4,
        REG_ROBOT_Y_CELLS = 3'd5,
        REG_CELLS_PER_MM  = 3'd6
    } t_reg_idx;

    // register reset values
    localparam logic [15:0] RST_START_ANGLE  = 16'd0;
    localparam logic [15:0] RST_ANGLE_STEP   = 16'd0;
    localparam logic [15:0] RST_RANGE_MIN_MM = 16'd0;
    localparam logic [15:0] RST_RANGE_MAX_MM = 16'hFFFF;
    localparam logic [24:0] RST_ROBOT_CELLS  = 25'd0;
    localparam logic [23:0] RST_CELLS_PER_MM = 24'd335544;

    // pi/2 in q2.30, used to build the quarter-wave sine rom
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // phase: 65536 units per turn, quarter = 2^14
    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    // widths of the fixed-point path
    localparam int unsigned TRIG_W   = 15;  // q0.15 magnitude
    localparam int unsigned PROD_W   = 40;  // range_mm * cells_per_mm
    localparam int unsigned FULL_W   = 55;  // times trig magnitude
    localparam int unsigned OFF_W    = 24;  // offset in q.8 cells after >> 31
    localparam int unsigned OFF_SH   = 31;
    localparam int unsigned END_W    = 26;  // robot + offset, signed

endpackage

@@ src/laser_scan_to_grid_cell_unit.sv @@
// lidar beam to occupancy grid cell index, six-stage pipeline with apb registers
`timescale 1ns / 1ps

// Usage:
// Input channel: i_valid / o_stall carry one beam word (i_beam_index, i_range_mm).
// A word is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one cell word (o_cell_index, o_beam_tag).
// Beams outside the range window, past MAX_BEAMS or landing off the grid give
// no output word; the others come out in input order.
// The stages, in order: angle multiply, rom address and range * scale product,
// sine/cosine rom read, trig multiply, endpoint add and grid check, then
// row * width + column into the output register. One beam per cycle is sustained
// while i_stall stays low; each stage holds one word. When i_stall is high the
// output word holds and the pipeline keeps filling its empty stages; input is
// stalled only once every stage holds a word. Registers are to be written over
// the apb port only while the block is idle; the block does not enforce it. Reset
// (i_rst_n low, synchronous) empties the pipeline and loads the register defaults.
// The sine rom is a constant table, so no fill pass follows reset.
module laser_scan_to_grid_cell_unit #(
    parameter int GRID_WIDTH       = 1024,
    parameter int GRID_HEIGHT      = 1024,
    parameter int MAX_BEAMS        = 4096,
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsgc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,

    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [11:0]                     i_beam_index,
    input  logic [15:0]                     i_range_mm,

    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [19:0]                     o_cell_index,
    output logic [11:0]                     o_beam_tag
);

    localparam int AW = $clog2(TRIG_TABLE_DEPTH + 1);
    localparam int CW = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
    localparam int RW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

    localparam int TW = lsgc_pkg::TRIG_W;
    localparam int PW = lsgc_pkg::PROD_W;
    localparam int FW = lsgc_pkg::FULL_W;
    localparam int OW = lsgc_pkg::OFF_W;
    localparam int EW = lsgc_pkg::END_W;

    // quarter-wave sine rom, q0.15, entries 0..TRIG_TABLE_DEPTH
    typedef logic [TW-1:0] t_sin_rom [0:TRIG_TABLE_DEPTH];

    function automatic t_sin_rom build_sin_rom();
        t_sin_rom          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        for (int k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
            x    = (longint'(k) * lsgc_pkg::HALF_PI_Q30) / TRIG_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            // taylor series to x^13
            term = ((term * x2) >> 30) / 6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 156;
            sum  = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 16384) >>> 15;
            if (sum > 32767) begin
                sum = 32767;
            end
            tab[k] = TW'(sum);
        end
        return tab;
    endfunction

    localparam t_sin_rom SIN_ROM = build_sin_rom();

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic        [15:0] r_start_angle;
    logic signed [15:0] r_angle_step;
    logic        [15:0] r_range_min_mm;
    logic        [15:0] r_range_max_mm;
    logic signed [24:0] r_robot_x_cells;
    logic signed [24:0] r_robot_y_cells;
    logic        [23:0] r_cells_per_mm;

    lsgc_pkg::t_reg_idx cfg_idx;
    logic               cfg_wr;

    assign cfg_idx = lsgc_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle   <= lsgc_pkg::RST_START_ANGLE;
            r_angle_step    <= $signed(lsgc_pkg::RST_ANGLE_STEP);
            r_range_min_mm  <= lsgc_pkg::RST_RANGE_MIN_MM;
            r_range_max_mm  <= lsgc_pkg::RST_RANGE_MAX_MM;
            r_robot_x_cells <= $signed(lsgc_pkg::RST_ROBOT_CELLS);
            r_robot_y_cells <= $signed(lsgc_pkg::RST_ROBOT_CELLS);
            r_cells_per_mm  <= lsgc_pkg::RST_CELLS_PER_MM;
        end else if (cfg_wr) begin
            case (cfg_idx)
                lsgc_pkg::REG_START_ANGLE:   r_start_angle   <= pwdata[15:0];
                lsgc_pkg::REG_ANGLE_STEP:    r_angle_step    <= $signed(pwdata[15:0]);
                lsgc_pkg::REG_RANGE_MIN_MM:  r_range_min_mm  <= pwdata[15:0];
                lsgc_pkg::REG_RANGE_MAX_MM:  r_range_max_mm  <= pwdata[15:0];
                lsgc_pkg::REG_ROBOT_X_CELLS: r_robot_x_cells <= $signed(pwdata[24:0]);
                lsgc_pkg::REG_ROBOT_Y_CELLS: r_robot_y_cells <= $signed(pwdata[24:0]);
                lsgc_pkg::REG_CELLS_PER_MM:  r_cells_per_mm  <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            lsgc_pkg::REG_START_ANGLE:   prdata = {16'd0, r_start_angle};
            lsgc_pkg::REG_ANGLE_STEP:    prdata = {16'd0, r_angle_step};
            lsgc_pkg::REG_RANGE_MIN_MM:  prdata = {16'd0, r_range_min_mm};
            lsgc_pkg::REG_RANGE_MAX_MM:  prdata = {16'd0, r_range_max_mm};
            lsgc_pkg::REG_ROBOT_X_CELLS: prdata = {7'd0, r_robot_x_cells};
            lsgc_pkg::REG_ROBOT_Y_CELLS: prdata = {7'd0, r_robot_y_cells};
            lsgc_pkg::REG_CELLS_PER_MM:  prdata = {8'd0, r_cells_per_mm};
            default:                     prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline flow control: a stage loads when it is empty or drains
    // ---------------------------------------------------------------
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r_out_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
    logic in_acc;

    assign rdy_out = !r_out_valid || !i_stall;
    assign rdy5    = !r5_v || rdy_out;
    assign rdy4    = !r4_v || rdy5;
    assign rdy3    = !r3_v || rdy4;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_stall = !rdy1;
    assign in_acc  = i_valid && rdy1;

    // ---------------------------------------------------------------
    // stage 1: range window, beam limit, beam angle
    // ---------------------------------------------------------------
    logic [27:0] beam_x_step;
    logic        n1_ok;
    logic [15:0] n1_angle;

    logic [11:0] r1_beam;
    logic [15:0] r1_range;
    logic [15:0] r1_angle;

    assign beam_x_step = 28'(i_beam_index) * 28'($unsigned(r_angle_step));
    assign n1_angle    = r_start_angle + beam_x_step[15:0];
    assign n1_ok       = ({5'd0, i_beam_index} < 17'(MAX_BEAMS))
                      && (i_range_mm >= r_range_min_mm)
                      && (i_range_mm <= r_range_max_mm);

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_beam  <= i_beam_index;
            r1_range <= i_range_mm;
            r1_angle <= n1_angle;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: rom addresses for sine and cosine, range * scale
    // ---------------------------------------------------------------
    logic [15:0]   cos_angle;
    logic [31:0]   k_sin_full, k_cos_full;
    logic [AW-1:0] k_sin, k_cos;
    logic [AW-1:0] n2_addr_s, n2_addr_c;
    logic [PW-1:0] n2_prod;

    logic [11:0]   r2_beam;
    logic [PW-1:0] r2_prod;
    logic [AW-1:0] r2_addr_s, r2_addr_c;
    logic          r2_neg_s, r2_neg_c;

    assign cos_angle  = r1_angle + lsgc_pkg::QUARTER_TURN;
    assign k_sin_full = (32'(r1_angle[13:0]) * 32'(TRIG_TABLE_DEPTH)) >> 14;
    assign k_cos_full = (32'(cos_angle[13:0]) * 32'(TRIG_TABLE_DEPTH)) >> 14;
    assign k_sin      = k_sin_full[AW-1:0];
    assign k_cos      = k_cos_full[AW-1:0];
    // odd quadrants read the table mirrored
    assign n2_addr_s  = r1_angle[14]  ? AW'(TRIG_TABLE_DEPTH) - k_sin : k_sin;
    assign n2_addr_c  = cos_angle[14] ? AW'(TRIG_TABLE_DEPTH) - k_cos : k_cos;
    assign n2_prod    = PW'(r1_range) * PW'(r_cells_per_mm);

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_beam   <= r1_beam;
            r2_prod   <= n2_prod;
            r2_addr_s <= n2_addr_s;
            r2_addr_c <= n2_addr_c;
            r2_neg_s  <= r1_angle[15];
            r2_neg_c  <= cos_angle[15];
        end
    end

    // ---------------------------------------------------------------
    // stage 3: rom read
    // ---------------------------------------------------------------
    logic [11:0]   r3_beam;
    logic [PW-1:0] r3_prod;
    logic [TW-1:0] r3_mag_s, r3_mag_c;
    logic          r3_neg_s, r3_neg_c;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_beam  <= r2_beam;
            r3_prod  <= r2_prod;
            r3_mag_s <= SIN_ROM[r2_addr_s];
            r3_mag_c <= SIN_ROM[r2_addr_c];
            r3_neg_s <= r2_neg_s;
            r3_neg_c <= r2_neg_c;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: offset magnitude in q.8 cells
    // ---------------------------------------------------------------
    logic [FW-1:0] full_x, full_y;

    logic [11:0]   r4_beam;
    logic [OW-1:0] r4_off_x, r4_off_y;
    logic          r4_neg_x, r4_neg_y;

    assign full_x = FW'(r3_prod) * FW'(r3_mag_c);
    assign full_y = FW'(r3_prod) * FW'(r3_mag_s);

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_beam  <= r3_beam;
            r4_off_x <= full_x[lsgc_pkg::OFF_SH +: OW];
            r4_off_y <= full_y[lsgc_pkg::OFF_SH +: OW];
            r4_neg_x <= r3_neg_c;
            r4_neg_y <= r3_neg_s;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: endpoint, truncation toward zero, grid bounds
    // ---------------------------------------------------------------
    logic signed [EW-1:0] off_x, off_y;
    logic signed [EW-1:0] end_x, end_y;
    logic                 in_x, in_y;
    logic [CW-1:0]        n5_cx;
    logic [RW-1:0]        n5_cy;

    logic [11:0]   r5_beam;
    logic [CW-1:0] r5_cx;
    logic [RW-1:0] r5_cy;

    assign off_x = r4_neg_x ? -$signed({2'b00, r4_off_x}) : $signed({2'b00, r4_off_x});
    assign off_y = r4_neg_y ? -$signed({2'b00, r4_off_y}) : $signed({2'b00, r4_off_y});
    assign end_x = EW'(r_robot_x_cells) + off_x;
    assign end_y = EW'(r_robot_y_cells) + off_y;

    // anything above -1.0 cell truncates to cell zero
    assign in_x  = end_x[EW-1] ? (end_x > -26'sd256)
                                : (end_x[EW-2:8] < 17'(GRID_WIDTH));
    assign in_y  = end_y[EW-1] ? (end_y > -26'sd256)
                                : (end_y[EW-2:8] < 17'(GRID_HEIGHT));
    assign n5_cx = end_x[EW-1] ? '0 : end_x[8 +: CW];
    assign n5_cy = end_y[EW-1] ? '0 : end_y[8 +: RW];

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5_beam <= r4_beam;
            r5_cx   <= n5_cx;
            r5_cy   <= n5_cy;
        end
    end

    // ---------------------------------------------------------------
    // output register: row-major index
    // ---------------------------------------------------------------
    logic [31:0] n_cell_full;
    logic [19:0] r_cell_index;
    logic [11:0] r_beam_tag;

    assign n_cell_full = 32'(r5_cy) * 32'(GRID_WIDTH) + 32'(r5_cx);

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_cell_index <= n_cell_full[19:0];
            r_beam_tag   <= r5_beam;
        end
    end

    // valid bits, rejected beams drop out where they are found
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_v <= in_acc && n1_ok;
            end
            if (rdy2) begin
                r2_v <= r1_v;
            end
            if (rdy3) begin
                r3_v <= r2_v;
            end
            if (rdy4) begin
                r4_v <= r3_v;
            end
            if (rdy5) begin
                r5_v <= r4_v && in_x && in_y;
            end
            if (rdy_out) begin
                r_out_valid <= r5_v;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cell_index = r_cell_index;
    assign o_beam_tag   = r_beam_tag;

endmodule

@@ bench/laser_scan_to_grid_cell_unit_test.sv @@
// self-checking bench for the lidar beam to grid cell unit, apb setup and random beams
`timescale 1ns / 1ps

module laser_scan_to_grid_cell_unit_test;

    localparam int GRID_W        = 1024;
    localparam int GRID_H        = 1024;
    localparam int BEAM_LIMIT    = 4096;
    localparam int TRIG_DEPTH    = 1024;
    localparam int SPARE_REG     = 7;     // first address past the register map
    localparam int DRAIN_CYCLES  = 12;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SWEEP_PHASES  = 12;
    localparam int BEAMS_PER_SET = 160;
    localparam int GRID_MID_Q8   = 512 * 256;

    typedef struct packed {
        logic [19:0] cell_idx;
        logic [11:0] tag;
    } t_cell_word;

    class grid_cell_tracker;
        localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

        int          sine_q15[TRIG_DEPTH + 1];
        t_cell_word  cells_due[$];
        int          errors;
        int          cells_seen;

        logic [15:0]        start_angle;
        logic [15:0]        angle_step;
        logic [15:0]        lo_range_mm;
        logic [15:0]        hi_range_mm;
        logic signed [24:0] robot_x;
        logic signed [24:0] robot_y;
        logic [23:0]        cells_per_mm;

        function new();
            longint unsigned x, x2, term;
            longint total;
            for (int k = 0; k <= TRIG_DEPTH; k++) begin
                x = (longint'(k) * PI_HALF_Q30) / TRIG_DEPTH;
                x2 = (x * x) >> 30;
                term = x;
                total = longint'(x);
                // taylor series out to x^13
                for (int n = 1; n <= 6; n++) begin
                    term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) total -= longint'(term);
                    else total += longint'(term);
                end
                if (total < 0) total = 0;
                total = (total + 16384) >>> 15;
                if (total > 32767) total = 32767;
                sine_q15[k] = int'(total);
            end
            errors = 0;
            cells_seen = 0;
            start_angle = lsgc_pkg::RST_START_ANGLE;
            angle_step = lsgc_pkg::RST_ANGLE_STEP;
            lo_range_mm = lsgc_pkg::RST_RANGE_MIN_MM;
            hi_range_mm = lsgc_pkg::RST_RANGE_MAX_MM;
            robot_x = lsgc_pkg::RST_ROBOT_CELLS;
            robot_y = lsgc_pkg::RST_ROBOT_CELLS;
            cells_per_mm = lsgc_pkg::RST_CELLS_PER_MM;
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        function void set_reg(int idx, logic [31:0] value);
            case (idx)
                lsgc_pkg::REG_START_ANGLE:   start_angle = value[15:0];
                lsgc_pkg::REG_ANGLE_STEP:    angle_step = value[15:0];
                lsgc_pkg::REG_RANGE_MIN_MM:  lo_range_mm = value[15:0];
                lsgc_pkg::REG_RANGE_MAX_MM:  hi_range_mm = value[15:0];
                lsgc_pkg::REG_ROBOT_X_CELLS: robot_x = value[24:0];
                lsgc_pkg::REG_ROBOT_Y_CELLS: robot_y = value[24:0];
                lsgc_pkg::REG_CELLS_PER_MM:  cells_per_mm = value[23:0];
                default: ;
            endcase
        endfunction

        function int sine_at(logic [15:0] a);
            int k, v;
            k = (a[13:0] * TRIG_DEPTH) >> 14;
            v = a[14] ? sine_q15[TRIG_DEPTH - k] : sine_q15[k];
            return a[15] ? -v : v;
        endfunction

        // offset in q.8 cells, magnitude truncated so the sign is symmetric
        function longint offset_q8(logic [15:0] range, int trig);
            longint unsigned mag, prod;
            mag = 64'((trig < 0) ? -trig : trig);
            prod = (range * cells_per_mm * mag) >> 31;
            return (trig < 0) ? -longint'(prod) : longint'(prod);
        endfunction

        function bit predict_cell(logic [11:0] beam, logic [15:0] range,
                                  output t_cell_word w);
            logic [15:0] ang, ang_cos;
            longint ex, ey, cx, cy;
            w = '0;
            if (int'(beam) >= BEAM_LIMIT || range < lo_range_mm || range > hi_range_mm)
                return 0;
            ang = start_angle + 16'(beam) * angle_step;
            ang_cos = ang + lsgc_pkg::QUARTER_TURN;
            ex = longint'(robot_x) + offset_q8(range, sine_at(ang_cos));
            ey = longint'(robot_y) + offset_q8(range, sine_at(ang));
            // signed division truncates toward zero
            cx = ex / 256;
            cy = ey / 256;
            if (cx < 0 || cx >= GRID_W || cy < 0 || cy >= GRID_H) return 0;
            w.cell_idx = 20'(cy * GRID_W + cx);
            w.tag = beam;
            return 1;
        endfunction

        function void note_beam(logic [11:0] beam, logic [15:0] range);
            t_cell_word w;
            if (predict_cell(beam, range, w)) cells_due.insert(cells_due.size(), w);
        endfunction

        task check_cell(logic [19:0] cell_idx, logic [11:0] tag);
            t_cell_word w;
            cells_seen++;
            if (cells_due.size() == 0) begin
                report($sformatf("cell %0d tag %0d with nothing expected", cell_idx, tag));
            end else begin
                w = cells_due.pop_front();
                if (cell_idx !== w.cell_idx)
                    report($sformatf("tag %0d cell %0d, expected %0d",
                                     w.tag, cell_idx, w.cell_idx));
                if (tag !== w.tag)
                    report($sformatf("beam tag %0d, expected %0d", tag, w.tag));
            end
        endtask

        function int waiting();
            return cells_due.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lsgc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            i_valid;
    logic                            o_stall;
    logic [11:0]                     i_beam_index;
    logic [15:0]                     i_range_mm;
    logic                            o_valid;
    logic                            i_stall;
    logic [19:0]                     o_cell_index;
    logic [11:0]                     o_beam_tag;

    grid_cell_tracker tracker;
    int  beams_taken = 0;
    int  idle_cycles = 0;
    int  settings_done = 0;
    int  gap_pct = 20;
    int  stall_pct = 20;
    bit  calm_tail = 1'b0;
    int  win_lo = 0;
    int  win_hi = 65535;

    laser_scan_to_grid_cell_unit #(
        .GRID_WIDTH(GRID_W),
        .GRID_HEIGHT(GRID_H),
        .MAX_BEAMS(BEAM_LIMIT),
        .TRIG_TABLE_DEPTH(TRIG_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_beam_index(i_beam_index),
        .i_range_mm(i_range_mm),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_cell_index(o_cell_index),
        .o_beam_tag(o_beam_tag)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sample both channels with the values that stood before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                tracker.note_beam(i_beam_index, i_range_mm);
                beams_taken++;
            end
            if (o_valid && !i_stall) tracker.check_cell(o_cell_index, o_beam_tag);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("FAIL laser_scan_to_grid_cell_unit");
                $finish;
            end
        end
    end

    // receiver back-pressure in bursts
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(int idx, logic [31:0] value);
        logic [lsgc_pkg::CFG_ADDR_W-1:0] addr;
        addr = lsgc_pkg::CFG_ADDR_W'(idx * 4);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic program_all(int start, int step, int rmin, int rmax,
                               int rx, int ry, int cpm);
        write_reg(lsgc_pkg::REG_START_ANGLE, start);
        write_reg(lsgc_pkg::REG_ANGLE_STEP, step);
        write_reg(lsgc_pkg::REG_RANGE_MIN_MM, rmin);
        write_reg(lsgc_pkg::REG_RANGE_MAX_MM, rmax);
        write_reg(lsgc_pkg::REG_ROBOT_X_CELLS, rx);
        write_reg(lsgc_pkg::REG_ROBOT_Y_CELLS, ry);
        write_reg(lsgc_pkg::REG_CELLS_PER_MM, cpm);
        win_lo = rmin;
        win_hi = rmax;
        settings_done++;
    endtask

    task automatic send_beam(logic [11:0] beam, logic [15:0] range);
        i_valid <= 1'b1;
        i_beam_index <= beam;
        i_range_mm <= range;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // empty the pipeline, including beams that give no word
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.waiting() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_range();
        if (win_lo <= win_hi && $urandom_range(0, 99) < 85)
            return 16'($urandom_range(win_lo, win_hi));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic choose_setting(int ph);
        int step;
        case (ph)
            0: program_all(65535, -32768, 0, 65535, 16777215, -16777216, 16777215);
            1: program_all(0, 32767, 0, 65535, GRID_MID_Q8, GRID_MID_Q8, 1);
            2: program_all($urandom_range(0, 65535), $urandom_range(0, 65535), 0, 700,
                           GRID_MID_Q8, GRID_MID_Q8, 16777215);
            3: program_all($urandom_range(0, 65535), 0, 65535, 65535,
                           GRID_MID_Q8, GRID_MID_Q8, 8000);
            default: begin
                step = $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 400) - 200;
                program_all($urandom_range(0, 65535), step, $urandom_range(0, 3000),
                            $urandom_range(20000, 65535),
                            $urandom_range(0, GRID_W * 256 - 1),
                            $urandom_range(0, GRID_H * 256 - 1),
                            $urandom_range(50000, 1200000));
            end
        endcase
    endtask

    initial begin
        int          base;
        bit          sweep;
        logic [11:0] beam;

        tracker = new();
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_valid <= 1'b0;
        i_beam_index <= '0;
        i_range_mm <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: angle zero, far beam runs off the grid
        send_beam(12'd0, 16'd0);
        send_beam(12'd0, 16'd20000);
        send_beam(12'd4095, 16'd65535);
        send_beam(12'd1, 16'd32768);
        settle();

        // quarter-turn steps from the grid middle, range window edges
        program_all(0, 16384, 1000, 30000, GRID_MID_Q8, GRID_MID_Q8, 335544);
        write_reg(SPARE_REG, 32'hFFFF_FFFF);
        for (int b = 0; b < 8; b++) send_beam(12'(b), 16'd20000);
        send_beam(12'd8, 16'd999);
        send_beam(12'd9, 16'd1000);
        send_beam(12'd10, 16'd30000);
        send_beam(12'd11, 16'd30001);
        settle();

        // just past half a turn from the origin: small negative offsets truncate to cell 0
        program_all(32868, 0, 0, 65535, 0, 0, 335544);
        send_beam(12'd5, 16'd10);
        send_beam(12'd6, 16'd300);
        settle();

        // empty window, min above max
        program_all(0, 100, 5000, 4000, GRID_MID_Q8, GRID_MID_Q8, 335544);
        send_beam(12'd0, 16'd4500);
        send_beam(12'd1, 16'd5000);
        send_beam(12'd2, 16'd4000);
        settle();

        for (int ph = 0; ph < SWEEP_PHASES; ph++) begin
            calm_tail = (ph >= SWEEP_PHASES - 2);
            choose_setting(ph);
            case ($urandom_range(0, 3))
                0: gap_pct = 0;
                1: gap_pct = 10;
                2: gap_pct = 30;
                default: gap_pct = 60;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 10;
                2: stall_pct = 30;
                default: stall_pct = 60;
            endcase
            sweep = 1'($urandom_range(0, 1));
            base = $urandom_range(0, 4095);
            for (int i = 0; i < BEAMS_PER_SET; i++) begin
                beam = sweep ? 12'(base + i) : 12'($urandom_range(0, 4095));
                send_beam(beam, pick_range());
            end
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (tracker.waiting() != 0)
            tracker.report($sformatf("%0d cell words never came out", tracker.waiting()));
        $display("run covered %0d beams and %0d cell words over %0d register settings",
                 beams_taken, tracker.cells_seen, settings_done);
        if (tracker.errors == 0) begin
            $display("PASS laser_scan_to_grid_cell_unit");
        end else begin
            $display("%0d mismatches", tracker.errors);
            $display("FAIL laser_scan_to_grid_cell_unit");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/lsgc_pkg.sv
src/laser_scan_to_grid_cell_unit.sv
bench/laser_scan_to_grid_cell_unit_test.sv
